>>> sv/alu64_pkg.sv
// Shared types for the signed add/subtract/multiply/divide unit.
package alu64_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic sign;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip_run;
  } dp_sts_t;

endpackage

>>> sv/alu64_dp.sv
// Datapath: operand registers, shift/add/subtract logic, sign fix.
module alu64_dp #(
  parameter int W = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  alu64_pkg::dp_cmd_t  cmd_i,
  output alu64_pkg::dp_sts_t  sts_o,
  input  logic [1:0]          command_i,
  input  logic [63:0]         left_operand_i,
  input  logic [63:0]         right_operand_i,
  output logic [63:0]         result_value_o
);
  import alu64_pkg::*;

  cmd_e         op_q;
  logic [W-1:0] x_q, y_q, acc_q, quo_q, res_q;
  logic         flip_q;

  logic [W-1:0] x_mag, y_mag, rem_sh, rem_sub, val;
  logic         rem_take;

  assign x_mag    = x_q[W-1] ? (~x_q + W'(1)) : x_q;
  assign y_mag    = y_q[W-1] ? (~y_q + W'(1)) : y_q;
  assign rem_sh   = {acc_q[W-2:0], x_q[W-1]};
  assign rem_sub  = rem_sh - y_q;
  // a set top bit before the shift means the true remainder exceeds the divisor
  assign rem_take = acc_q[W-1] || (rem_sh >= y_q);
  assign val      = (op_q == CMD_MUL) ? acc_q : quo_q;

  assign sts_o.skip_run = (op_q == CMD_ADD) || (op_q == CMD_SUB) ||
                          ((op_q == CMD_DIV) && ((x_q == '0) || (y_q == '0)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= CMD_ADD;
    end else if (cmd_i.load) begin
      op_q <= cmd_e'(command_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= left_operand_i[W-1:0];
      y_q <= right_operand_i[W-1:0];
    end else if (cmd_i.setup) begin
      flip_q <= x_q[W-1] ^ y_q[W-1];
      x_q    <= x_mag;
      y_q    <= y_mag;
      acc_q  <= '0;
      quo_q  <= '0;
      case (op_q)
        CMD_ADD: res_q <= x_q + y_q;
        CMD_SUB: res_q <= x_q - y_q;
        default: res_q <= '0;
      endcase
    end else if (cmd_i.step) begin
      x_q <= {x_q[W-2:0], 1'b0};
      if (op_q == CMD_MUL) begin
        y_q <= {1'b0, y_q[W-1:1]};
        if (y_q[0]) begin
          acc_q <= acc_q + x_q;
        end
      end else begin
        quo_q <= {quo_q[W-2:0], rem_take};
        acc_q <= rem_take ? rem_sub : rem_sh;
      end
    end else if (cmd_i.sign) begin
      res_q <= flip_q ? (~val + W'(1)) : val;
    end
  end

  assign result_value_o = 64'(signed'(res_q));

endmodule

>>> sv/alu64_ctrl.sv
// Controller: sequencing state machine, bit counter and handshakes.
module alu64_ctrl #(
  parameter int W = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output alu64_pkg::dp_cmd_t  cmd_o,
  input  alu64_pkg::dp_sts_t  sts_i
);
  import alu64_pkg::*;

  localparam int CW = $clog2(W);

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            last;
  logic            in_acc;

  assign last   = (cnt_q == CW'(W - 1));
  assign in_acc = in_valid_i && !in_stall_o;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);

  assign cmd_o.load  = in_acc;
  assign cmd_o.setup = (state_q == ST_SETUP);
  assign cmd_o.step  = (state_q == ST_RUN);
  assign cmd_o.sign  = (state_q == ST_SIGN);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        cnt_d   = '0;
        state_d = sts_i.skip_run ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        cnt_d = cnt_q + CW'(1);
        if (last) state_d = ST_SIGN;
      end
      ST_SIGN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SETUP))
    else $error("accepted transaction did not enter setup");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && last) |=> (state_q == ST_SIGN))
    else $error("iteration did not end after the last bit");

  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP && !sts_i.skip_run) |=> (state_q == ST_RUN && cnt_q == '0))
    else $error("iteration started with a stale count");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(cmd_o)))
    else $error("stalled result dropped");

endmodule

>>> sv/signed_64bit_add_sub_mul_div.sv
// Top level of the signed add/subtract/multiply/divide unit.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+-------------------------------------------
//  input   | in_valid_i | in_stall_o  | command_i, left_operand_i, right_operand_i
//  output  | out_valid_o| out_stall_i | result_value_o
//
// Add/subtract: the result is registered in the setup state and shown in done.
// Multiply/divide: setup, one bit per cycle through the add/subtract-compare
// logic for WORD_WIDTH bits, sign fix, then done.
// Divide by zero or a zero dividend skips the iteration and the sign fix.
// One transaction at a time; input stalls until the result is taken.
// Reset is asynchronous, active low, and returns the controller to idle.
module signed_64bit_add_sub_mul_div #(
  parameter int WORD_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] left_operand_i,
  input  logic [63:0] right_operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_value_o
);
  import alu64_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  alu64_ctrl #(.W(WORD_WIDTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  alu64_dp #(.W(WORD_WIDTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .command_i       (command_i),
    .left_operand_i  (left_operand_i),
    .right_operand_i (right_operand_i),
    .result_value_o  (result_value_o)
  );

endmodule

>>> dv/signed_64bit_add_sub_mul_div_tb.sv
// Self-checking testbench for the signed 64-bit add/subtract/multiply/divide unit.
`timescale 1ns / 1ps

module signed_64bit_add_sub_mul_div_tb;
  import alu64_pkg::*;

  localparam logic [63:0] MIN_S64  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_S64  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          MAX_REPORTS  = 200;

  typedef struct {
    cmd_e        cmd;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [63:0] result;
  } alu_txn_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  cmd_e        command_i       = CMD_ADD;
  logic [63:0] left_operand_i  = '0;
  logic [63:0] right_operand_i = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [63:0] result_value_o;

  alu_txn_t pending_results[$];
  int       mismatch_count     = 0;
  int       result_hold_cycles = 0;
  bit       sink_stalls_on     = 1'b1;
  int       sink_max_stall     = 4;

  signed_64bit_add_sub_mul_div DUT (.*);

  always #1 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Expected result of one operation at the full 64-bit width.
  function automatic logic [63:0] predict_alu_result(cmd_e cmd, logic [63:0] lhs,
                                                     logic [63:0] rhs);
    logic [63:0] mag_l;
    logic [63:0] mag_r;
    logic [63:0] res;
    logic        flip;
    mag_l = lhs[63] ? -lhs : lhs;
    mag_r = rhs[63] ? -rhs : rhs;
    flip  = lhs[63] ^ rhs[63];
    case (cmd)
      CMD_ADD: res = lhs + rhs;
      CMD_SUB: res = lhs - rhs;
      CMD_MUL: begin
        res = mag_l * mag_r;
        if (flip) res = -res;
      end
      default: begin
        if (lhs == '0 || rhs == '0) begin
          res = '0;
        end else begin
          // magnitude of the most negative value is 2^63, taken unsigned
          res = mag_l / mag_r;
          if (flip) res = -res;
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      4: v = v >> $urandom_range(1, 63);
      5: v = -(v >> $urandom_range(1, 63));
      6: v = 64'($urandom_range(0, 40)) - 64'd20;
      7: v = 64'd1 << $urandom_range(0, 63);
      8: v = -(64'd1 << $urandom_range(0, 63));
      9: begin
        case ($urandom_range(0, 4))
          0: v = MIN_S64;
          1: v = MAX_S64;
          2: v = '0;
          3: v = ALL_ONES;
          default: v = 64'd1;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Valid is left high on return; the caller lowers it through idle_sender or wait_all_results.
  task automatic send_op(cmd_e cmd, logic [63:0] lhs, logic [63:0] rhs);
    alu_txn_t txn;
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    left_operand_i  <= lhs;
    right_operand_i <= rhs;
    do @(posedge clk_i); while (in_stall_o);
    txn.cmd    = cmd;
    txn.lhs    = lhs;
    txn.rhs    = rhs;
    txn.result = predict_alu_result(cmd, lhs, rhs);
    pending_results.push_back(txn);
  endtask

  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Result sink: stall runs of random length, or a long counted hold on request.
  initial begin : result_sink
    int run_left;
    bit stalling;
    run_left = 0;
    stalling = 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (result_hold_cycles) @(posedge clk_i);
        result_hold_cycles = 0;
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          run_left = stalling ? $urandom_range(1, sink_max_stall) : $urandom_range(1, 10);
        end
        run_left--;
        out_stall_i <= stalling && sink_stalls_on;
      end
    end
  end

  always @(posedge clk_i) begin
    alu_txn_t exp_txn;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no transaction outstanding",
                                  result_value_o));
      end else begin
        exp_txn = pending_results.pop_front();
        if (result_value_o !== exp_txn.result)
          report_mismatch($sformatf("%s %h, %h: result_value %h, expected %h",
                                    exp_txn.cmd.name(), exp_txn.lhs, exp_txn.rhs,
                                    result_value_o, exp_txn.result));
      end
    end
  end

  task automatic test_edge_operands();
    // wraparound on add/subtract
    send_op(CMD_ADD, MAX_S64, 64'd1);
    send_op(CMD_ADD, MIN_S64, ALL_ONES);
    send_op(CMD_ADD, ALL_ONES, 64'd1);
    send_op(CMD_SUB, MIN_S64, 64'd1);
    send_op(CMD_SUB, '0, MIN_S64);
    // multiply overflow and signs
    send_op(CMD_MUL, MAX_S64, MAX_S64);
    send_op(CMD_MUL, MIN_S64, ALL_ONES);
    send_op(CMD_MUL, MIN_S64, 64'd1);
    send_op(CMD_MUL, -64'd3, 64'd7);
    send_op(CMD_MUL, '0, -64'd5);
    send_op(CMD_MUL, ALL_ONES, ALL_ONES);
    // divide by zero, zero dividend, most negative dividend
    send_op(CMD_DIV, 64'd7, '0);
    send_op(CMD_DIV, MIN_S64, '0);
    send_op(CMD_DIV, '0, 64'd5);
    send_op(CMD_DIV, MIN_S64, ALL_ONES);
    send_op(CMD_DIV, MIN_S64, 64'd1);
    send_op(CMD_DIV, MIN_S64, 64'd3);
    send_op(CMD_DIV, MIN_S64, MIN_S64);
    send_op(CMD_DIV, MAX_S64, MIN_S64);
    send_op(CMD_DIV, -64'd7, 64'd2);
    send_op(CMD_DIV, 64'd7, -64'd2);
    send_op(CMD_DIV, -64'd7, -64'd2);
    send_op(CMD_DIV, 64'd1, MAX_S64);
    send_op(CMD_DIV, ALL_ONES, ALL_ONES);
    wait_all_results();
  endtask

  task automatic test_back_to_back(int count);
    sink_stalls_on = 1'b0;
    for (int i = 0; i < count; i++)
      send_op(cmd_e'($urandom_range(0, 3)), rand_operand(), rand_operand());
    wait_all_results();
    sink_stalls_on = 1'b1;
  endtask

  // Hold the result port so the unit fills and stalls its input.
  task automatic test_result_hold_off();
    result_hold_cycles = 250;
    for (int i = 0; i < 4; i++)
      send_op(i[0] ? CMD_MUL : CMD_DIV, rand_operand(), rand_operand());
    wait_all_results();
  endtask

  task automatic test_random_traffic(int count);
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left     = $urandom_range(1, 12);
        sink_stalls_on = ($urandom_range(0, 4) != 0);
        sink_max_stall = ($urandom_range(0, 3) == 0) ? 30 : 4;
        if ($urandom_range(0, 5) == 0) idle_sender($urandom_range(20, 70));
        else idle_sender($urandom_range(0, 4));
      end
      burst_left--;
      if (i % 300 == 299) wait_all_results();
      send_op(cmd_e'($urandom_range(0, 3)), rand_operand(), rand_operand());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_operands();
    test_back_to_back(80);
    test_result_hold_off();
    test_random_traffic(1400);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
